>>> hdl/hist3d_pkg.sv
// ---------------------------------------------------------------------------
// hist3d_pkg
// Shared types and constants for the 3-D histogram binning core.
// ---------------------------------------------------------------------------
package hist3d_pkg;

   localparam int DEF_MAX_BINS    = 32;
   localparam int DEF_COUNT_WIDTH = 32;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 5;
   localparam int CMD_W    = 2;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 16;
   localparam int BINSREG_W = 6;
   localparam int OUT_W    = 32;
   localparam int NZ_W     = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_RDSMP = 2'd1,
      CMD_RDIDX = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_MIN_X = 3'd0,
      CSR_MAX_X = 3'd1,
      CSR_MIN_Y = 3'd2,
      CSR_MAX_Y = 3'd3,
      CSR_MIN_Z = 3'd4,
      CSR_MAX_Z = 3'd5,
      CSR_BINS  = 3'd6
   } csr_idx_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_DIV  = 8'b0000_0100,
      ST_ADDR = 8'b0000_1000,
      ST_RD   = 8'b0001_0000,
      ST_MOD  = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_CLR  = 8'b1000_0000
   } state_type;

endpackage

>>> hdl/hist3d_div.sv
// ---------------------------------------------------------------------------
// hist3d_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hist3d_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 16,
   parameter int QW    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QW-1:0]    quot
);
   localparam int CW = $clog2(QW + 1);
   localparam int TW = NUM_W + 1;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [TW-1:0]    shd, diff;

   always_comb begin
      shd     = TW'(den_ff) << cnt_ff;
      diff    = TW'(rem_ff) - shd;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         cnt_in  = CW'(QW - 1);
         busy_in = 1'b1;
         q_in    = '0;
      end else if (busy_ff) begin
         if (TW'(rem_ff) >= shd) begin
            rem_in = diff[NUM_W-1:0];
            q_in   = q_ff | (QW'(1) << cnt_ff);
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> hdl/hist3d_ram.sv
// ---------------------------------------------------------------------------
// hist3d_ram
// Single-port-write, single-port-read bin memory, registered read data.
// ---------------------------------------------------------------------------
module hist3d_ram #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/histogram_3d_binning_core.sv
// ---------------------------------------------------------------------------
// histogram_3d_binning_core
// 3-D histogram of 16-bit samples with saturating bin counters in a memory.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  req_    | in  | req_valid/req_stall  | cmd, sample_x/y/z, masked, index_x/y/z
//  rsp_    | out | rsp_valid/rsp_stall  | bin_count, flags, bin_x/y/z, statistics
//  csr_    | in  | csr_we               | csr_index, csr_wdata (no read-back)
//
//  Add / read-by-sample: each axis in turn through the shared divider, then
//  address, memory read, update and result. Read by index skips the divider.
//  Clear writes zero to every bin. Reset starts a clearing pass over all
//  MAX_BINS^3 bins; req_stall stays high.
//  One word at a time; the result register lets the next word be accepted
//  while a result still waits on rsp_stall.
// ---------------------------------------------------------------------------
module histogram_3d_binning_core #(
   parameter int MAX_BINS    = hist3d_pkg::DEF_MAX_BINS,
   parameter int COUNT_WIDTH = hist3d_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [hist3d_pkg::CMD_W-1:0]          req_cmd,
   input  logic [hist3d_pkg::SAMPLE_W-1:0]       req_sample_x,
   input  logic [hist3d_pkg::SAMPLE_W-1:0]       req_sample_y,
   input  logic [hist3d_pkg::SAMPLE_W-1:0]       req_sample_z,
   input  logic                                  req_masked,
   input  logic [hist3d_pkg::INDEX_W-1:0]        req_index_x,
   input  logic [hist3d_pkg::INDEX_W-1:0]        req_index_y,
   input  logic [hist3d_pkg::INDEX_W-1:0]        req_index_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hist3d_pkg::OUT_W-1:0]          rsp_bin_count,
   output logic                                  rsp_in_range,
   output logic                                  rsp_bad_range,
   output logic [hist3d_pkg::INDEX_W-1:0]        rsp_bin_x,
   output logic [hist3d_pkg::INDEX_W-1:0]        rsp_bin_y,
   output logic [hist3d_pkg::INDEX_W-1:0]        rsp_bin_z,
   output logic [hist3d_pkg::OUT_W-1:0]          rsp_total_samples,
   output logic [hist3d_pkg::OUT_W-1:0]          rsp_max_bin_count,
   output logic [hist3d_pkg::NZ_W-1:0]           rsp_distinct_bins,
   input  logic                                  csr_we,
   input  logic [hist3d_pkg::CSR_IW-1:0]         csr_index,
   input  logic [hist3d_pkg::CSR_DW-1:0]         csr_wdata
);
   import hist3d_pkg::*;

   localparam int CUBE   = MAX_BINS * MAX_BINS * MAX_BINS;
   localparam int AW     = $clog2(CUBE);
   localparam int BW     = $clog2(MAX_BINS);
   localparam int NB_W   = $clog2(MAX_BINS + 1);
   localparam int NUM_W  = SAMPLE_W + BW;
   localparam int CW     = COUNT_WIDTH;

   // config registers
   logic [SAMPLE_W-1:0]  lo_ff [3];
   logic [SAMPLE_W-1:0]  hi_ff [3];
   logic [BINSREG_W-1:0] bins_reg_ff;

   // sequencer
   state_type           state_ff, state_in;
   cmd_type             cmd_ff;
   logic [SAMPLE_W-1:0] smp_ff [3];
   logic [1:0]          axis_ff;
   logic [BW-1:0]       bx_ff, by_ff, bz_ff;
   logic                ok_ff;
   logic [AW-1:0]       addr_ff;
   logic [AW-1:0]       clr_ff;
   logic                clr_reply_ff;
   logic [CW-1:0]       cnt_ff;

   // statistics
   logic [OUT_W-1:0] total_ff;
   logic [CW-1:0]    largest_ff;
   logic [NZ_W-1:0]  nonempty_ff;

   // result register
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_count_ff, rsp_total_ff, rsp_max_ff;
   logic                rsp_ok_ff, rsp_bad_ff;
   logic [INDEX_W-1:0]  rsp_bx_ff, rsp_by_ff, rsp_bz_ff;
   logic [NZ_W-1:0]     rsp_nz_ff;

   logic [NB_W-1:0]   bins_used;
   logic              bad_any;
   logic [2:0]        axis_ok;
   logic [SAMPLE_W-1:0] req_smp [3];
   logic              accept;
   logic [SAMPLE_W-1:0] v_sel, lo_sel, hi_sel;
   logic [NUM_W-1:0]  div_num;
   logic              div_start, div_done;
   logic [BW-1:0]     div_q;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr;
   logic [CW-1:0]     ram_wdata, ram_rdata;
   logic [CW-1:0]     new_cnt;
   logic [AW-1:0]     addr_calc;
   logic              idx_ok;
   logic [63:0]       cnt_ext, max_ext;

   // bins_in_use clamped into [2, MAX_BINS]
   always_comb begin
      if (bins_reg_ff < BINSREG_W'(2))
         bins_used = NB_W'(2);
      else if (32'(bins_reg_ff) > 32'(MAX_BINS))
         bins_used = NB_W'(MAX_BINS);
      else
         bins_used = NB_W'(bins_reg_ff);
   end

   assign req_smp[0] = req_sample_x;
   assign req_smp[1] = req_sample_y;
   assign req_smp[2] = req_sample_z;

   always_comb begin
      bad_any = 1'b0;
      for (int a = 0; a < 3; a++) begin
         bad_any    = bad_any | (hi_ff[a] <= lo_ff[a]);
         axis_ok[a] = (hi_ff[a] > lo_ff[a]) && (req_smp[a] >= lo_ff[a])
                      && (req_smp[a] <= hi_ff[a]);
      end
   end

   assign idx_ok = (32'(req_index_x) < 32'(bins_used)) && (32'(req_index_y) < 32'(bins_used))
                   && (32'(req_index_z) < 32'(bins_used));

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // one axis at a time through the shared divider
   always_comb begin
      case (axis_ff)
         2'd0:    begin v_sel = smp_ff[0]; lo_sel = lo_ff[0]; hi_sel = hi_ff[0]; end
         2'd1:    begin v_sel = smp_ff[1]; lo_sel = lo_ff[1]; hi_sel = hi_ff[1]; end
         default: begin v_sel = smp_ff[2]; lo_sel = lo_ff[2]; hi_sel = hi_ff[2]; end
      endcase
   end

   assign div_start = (state_ff == ST_MUL);
   assign div_num   = NUM_W'(v_sel - lo_sel) * NUM_W'(bins_used - 1'b1);

   hist3d_div #(.NUM_W(NUM_W), .DEN_W(SAMPLE_W), .QW(BW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (hi_sel - lo_sel),
      .done  (div_done),
      .quot  (div_q)
   );

   assign addr_calc = (AW'(bx_ff) * AW'(MAX_BINS) + AW'(by_ff)) * AW'(MAX_BINS) + AW'(bz_ff);

   // saturating increment of the bin just read
   assign new_cnt = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

   assign ram_re    = (state_ff == ST_RD);
   assign ram_we    = (state_ff == ST_CLR) || ((state_ff == ST_MOD) && (cmd_ff == CMD_ADD));
   assign ram_waddr = (state_ff == ST_CLR) ? clr_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_CLR) ? '0 : new_cnt;

   hist3d_ram #(.DEPTH(CUBE), .AW(AW), .DW(CW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: state_in = ST_CLR;
                  CMD_RDIDX: state_in = idx_ok ? ST_ADDR : ST_FIN;
                  default:   state_in = (!req_masked && (&axis_ok)) ? ST_MUL : ST_FIN;
               endcase
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = (axis_ff == 2'd2) ? ST_ADDR : ST_MUL;
         ST_ADDR: state_in = ST_RD;
         ST_RD:   state_in = ST_MOD;
         ST_MOD:  state_in = ST_FIN;
         ST_FIN:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         ST_CLR:  if (clr_ff == AW'(CUBE - 1)) state_in = clr_reply_ff ? ST_FIN : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         largest_ff   <= '0;
         nonempty_ff  <= '0;
         lo_ff[0] <= '0; lo_ff[1] <= '0; lo_ff[2] <= '0;
         hi_ff[0] <= '1; hi_ff[1] <= '1; hi_ff[2] <= '1;
         bins_reg_ff  <= BINSREG_W'(32);
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_MIN_X: lo_ff[0]    <= csr_wdata;
               CSR_MAX_X: hi_ff[0]    <= csr_wdata;
               CSR_MIN_Y: lo_ff[1]    <= csr_wdata;
               CSR_MAX_Y: hi_ff[1]    <= csr_wdata;
               CSR_MIN_Z: lo_ff[2]    <= csr_wdata;
               CSR_MAX_Z: hi_ff[2]    <= csr_wdata;
               CSR_BINS:  bins_reg_ff <= csr_wdata[BINSREG_W-1:0];
               default:   ;
            endcase
         end

         if (state_ff == ST_CLR) clr_ff <= clr_ff + 1'b1;

         if (accept && (cmd_type'(req_cmd) == CMD_CLEAR)) begin
            clr_ff       <= '0;
            clr_reply_ff <= 1'b1;
            total_ff     <= '0;
            largest_ff   <= '0;
            nonempty_ff  <= '0;
         end

         // statistics update on a counted sample
         if (state_ff == ST_MOD && cmd_ff == CMD_ADD) begin
            if (ram_rdata == '0 && nonempty_ff != '1) nonempty_ff <= nonempty_ff + 1'b1;
            if (new_cnt > largest_ff) largest_ff <= new_cnt;
            if (total_ff != '1) total_ff <= total_ff + 1'b1;
         end

         if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
      end

      // payload and datapath registers
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         smp_ff[0] <= req_sample_x;
         smp_ff[1] <= req_sample_y;
         smp_ff[2] <= req_sample_z;
         axis_ff   <= 2'd0;
         cnt_ff    <= '0;
         case (cmd_type'(req_cmd))
            CMD_CLEAR: ok_ff <= 1'b0;
            CMD_RDIDX: ok_ff <= idx_ok;
            default:   ok_ff <= !req_masked && (&axis_ok);
         endcase
         if (cmd_type'(req_cmd) == CMD_RDIDX && idx_ok) begin
            bx_ff <= BW'(req_index_x);
            by_ff <= BW'(req_index_y);
            bz_ff <= BW'(req_index_z);
         end else begin
            bx_ff <= '0;
            by_ff <= '0;
            bz_ff <= '0;
         end
      end
      if (state_ff == ST_DIV && div_done) begin
         case (axis_ff)
            2'd0:    bx_ff <= div_q;
            2'd1:    by_ff <= div_q;
            default: bz_ff <= div_q;
         endcase
         axis_ff <= axis_ff + 1'b1;
      end
      if (state_ff == ST_ADDR) addr_ff <= addr_calc;
      if (state_ff == ST_MOD) cnt_ff <= (cmd_ff == CMD_ADD) ? new_cnt : ram_rdata;
      if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_count_ff <= cnt_ext[63:32] != '0 ? '1 : cnt_ext[31:0];
         rsp_ok_ff    <= ok_ff;
         rsp_bad_ff   <= bad_any;
         rsp_bx_ff    <= INDEX_W'(bx_ff);
         rsp_by_ff    <= INDEX_W'(by_ff);
         rsp_bz_ff    <= INDEX_W'(bz_ff);
         rsp_total_ff <= total_ff;
         rsp_max_ff   <= max_ext[63:32] != '0 ? '1 : max_ext[31:0];
         rsp_nz_ff    <= nonempty_ff;
      end
   end

   assign cnt_ext = 64'(cnt_ff);
   assign max_ext = 64'(largest_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_count     = rsp_count_ff;
   assign rsp_in_range      = rsp_ok_ff;
   assign rsp_bad_range     = rsp_bad_ff;
   assign rsp_bin_x         = rsp_bx_ff;
   assign rsp_bin_y         = rsp_by_ff;
   assign rsp_bin_z         = rsp_bz_ff;
   assign rsp_total_samples = rsp_total_ff;
   assign rsp_max_bin_count = rsp_max_ff;
   assign rsp_distinct_bins = rsp_nz_ff;

   // bin writes during an update come only from add commands
   a_write_add: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == ST_MOD) |-> cmd_ff == CMD_ADD)
      else $error("bin write outside add");

   // nonempty bins never exceed counted samples
   a_nz_total: assert property (@(posedge clock) disable iff (reset)
      32'(nonempty_ff) <= total_ff)
      else $error("nonempty count above total");

   // largest count is zero exactly when nothing was counted
   a_max_total: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) == (largest_ff == '0))
      else $error("largest count inconsistent with total");

   // divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done out of sequence");

endmodule

>>> test/hist3d_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hist3d_checker
// Watches the request, response and register ports of the histogram core.
// Keeps its own cube of bin counters and its own statistics. Each accepted
// request word yields one predicted response word, and each response word is
// compared with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module hist3d_checker
   import hist3d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [SAMPLE_W-1:0]   req_sample_x,
   input  logic [SAMPLE_W-1:0]   req_sample_y,
   input  logic [SAMPLE_W-1:0]   req_sample_z,
   input  logic                  req_masked,
   input  logic [INDEX_W-1:0]    req_index_x,
   input  logic [INDEX_W-1:0]    req_index_y,
   input  logic [INDEX_W-1:0]    req_index_z,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [OUT_W-1:0]      rsp_bin_count,
   input  logic                  rsp_in_range,
   input  logic                  rsp_bad_range,
   input  logic [INDEX_W-1:0]    rsp_bin_x,
   input  logic [INDEX_W-1:0]    rsp_bin_y,
   input  logic [INDEX_W-1:0]    rsp_bin_z,
   input  logic [OUT_W-1:0]      rsp_total_samples,
   input  logic [OUT_W-1:0]      rsp_max_bin_count,
   input  logic [NZ_W-1:0]       rsp_distinct_bins,
   input  logic                  csr_we,
   input  logic [CSR_IW-1:0]     csr_index,
   input  logic [CSR_DW-1:0]     csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int NB = DEF_MAX_BINS;

   typedef struct packed {
      logic [OUT_W-1:0]   bin_count;
      logic               in_range;
      logic               bad_range;
      logic [INDEX_W-1:0] bin_x;
      logic [INDEX_W-1:0] bin_y;
      logic [INDEX_W-1:0] bin_z;
      logic [OUT_W-1:0]   total;
      logic [OUT_W-1:0]   largest;
      logic [NZ_W-1:0]    distinct;
   } bin_word_type;

   logic [SAMPLE_W-1:0] lo_reg [3];
   logic [SAMPLE_W-1:0] hi_reg [3];
   logic [BINSREG_W-1:0] bins_reg;
   logic [OUT_W-1:0] cube [NB*NB*NB];
   logic [OUT_W-1:0] total_q, largest_q;
   logic [NZ_W-1:0]  distinct_q;
   bin_word_type     expected_words [$];

   assign pending = expected_words.size();

   task automatic report(input string what, input logic [OUT_W-1:0] got,
                         input logic [OUT_W-1:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Bin of one component; 0 flags out of range or a bad axis.
   function automatic logic map_axis(input int axis, input logic [SAMPLE_W-1:0] v,
                                     input int nbins, output logic [INDEX_W-1:0] b);
      int unsigned span, off;
      b = '0;
      if (hi_reg[axis] <= lo_reg[axis] || v < lo_reg[axis] || v > hi_reg[axis])
         return 1'b0;
      span = hi_reg[axis] - lo_reg[axis];
      off  = v - lo_reg[axis];
      b = INDEX_W'((off * (nbins - 1)) / span);
      return 1'b1;
   endfunction

   function automatic bin_word_type bin_update(input cmd_type cmd,
                                               input logic [SAMPLE_W-1:0] s [3],
                                               input logic m,
                                               input logic [INDEX_W-1:0] ix [3]);
      bin_word_type w;
      int nbins;
      logic ok;
      logic [INDEX_W-1:0] b [3];
      int addr;
      nbins = (bins_reg < 2) ? 2 : (bins_reg > NB) ? NB : bins_reg;
      w = '0;
      w.bad_range = (hi_reg[0] <= lo_reg[0]) || (hi_reg[1] <= lo_reg[1]) ||
                    (hi_reg[2] <= lo_reg[2]);
      ok = 1'b0;
      b[0] = '0; b[1] = '0; b[2] = '0;
      if (cmd == CMD_CLEAR) begin
         foreach (cube[i]) cube[i] = '0;
         total_q = '0; largest_q = '0; distinct_q = '0;
      end else begin
         if (cmd == CMD_RDIDX) begin
            ok = ix[0] < nbins && ix[1] < nbins && ix[2] < nbins;
            b = ix;
         end else begin
            ok = !m && map_axis(0, s[0], nbins, b[0]) && map_axis(1, s[1], nbins, b[1])
                 && map_axis(2, s[2], nbins, b[2]);
         end
         if (ok) begin
            addr = (b[0] * NB + b[1]) * NB + b[2];
            if (cmd == CMD_ADD) begin
               if (cube[addr] == '0 && distinct_q != '1) distinct_q++;
               if (cube[addr] != '1) cube[addr]++;
               if (cube[addr] > largest_q) largest_q = cube[addr];
               if (total_q != '1) total_q++;
            end
            w.bin_count = cube[addr];
            w.bin_x = b[0]; w.bin_y = b[1]; w.bin_z = b[2];
         end
      end
      w.in_range = ok;
      w.total = total_q;
      w.largest = largest_q;
      w.distinct = distinct_q;
      return w;
   endfunction

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] s [3];
      logic [INDEX_W-1:0]  ix [3];
      bin_word_type want;
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            lo_reg[a] = '0;
            hi_reg[a] = '1;
         end
         bins_reg = 6'd32;
         foreach (cube[i]) cube[i] = '0;
         total_q = '0; largest_q = '0; distinct_q = '0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_MIN_X: lo_reg[0] = csr_wdata;
               CSR_MAX_X: hi_reg[0] = csr_wdata;
               CSR_MIN_Y: lo_reg[1] = csr_wdata;
               CSR_MAX_Y: hi_reg[1] = csr_wdata;
               CSR_MIN_Z: lo_reg[2] = csr_wdata;
               CSR_MAX_Z: hi_reg[2] = csr_wdata;
               CSR_BINS:  bins_reg  = csr_wdata[BINSREG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_bin_count, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_bin_count !== want.bin_count)
                  report("bin_count", rsp_bin_count, want.bin_count);
               if (rsp_in_range !== want.in_range)
                  report("in_range", OUT_W'(rsp_in_range), OUT_W'(want.in_range));
               if (rsp_bad_range !== want.bad_range)
                  report("bad_range", OUT_W'(rsp_bad_range), OUT_W'(want.bad_range));
               if (rsp_bin_x !== want.bin_x)
                  report("bin_x", OUT_W'(rsp_bin_x), OUT_W'(want.bin_x));
               if (rsp_bin_y !== want.bin_y)
                  report("bin_y", OUT_W'(rsp_bin_y), OUT_W'(want.bin_y));
               if (rsp_bin_z !== want.bin_z)
                  report("bin_z", OUT_W'(rsp_bin_z), OUT_W'(want.bin_z));
               if (rsp_total_samples !== want.total)
                  report("total_samples", rsp_total_samples, want.total);
               if (rsp_max_bin_count !== want.largest)
                  report("max_bin_count", rsp_max_bin_count, want.largest);
               if (rsp_distinct_bins !== want.distinct)
                  report("distinct_bins", OUT_W'(rsp_distinct_bins), OUT_W'(want.distinct));
            end
         end
         if (req_valid && !req_stall) begin
            s[0] = req_sample_x; s[1] = req_sample_y; s[2] = req_sample_z;
            ix[0] = req_index_x; ix[1] = req_index_y; ix[2] = req_index_z;
            expected_words.push_back(bin_update(cmd_type'(req_cmd), s, req_masked, ix));
         end
      end
   end

   initial fail_count = 0;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for histogram_3d_binning_core.
// A directed pass hits the range borders, masking, every command and clear;
// then random phases under varied axis ranges and bin counts, with random
// gaps on both channels. Checking lives in hist3d_checker.
// ---------------------------------------------------------------------------
module tb;
   import hist3d_pkg::*;

   localparam int CYCLE_LIMIT = 5_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = CMD_ADD;
   logic [SAMPLE_W-1:0] req_sample_x = '0, req_sample_y = '0, req_sample_z = '0;
   logic                req_masked = 1'b0;
   logic [INDEX_W-1:0]  req_index_x = '0, req_index_y = '0, req_index_z = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b1;
   logic [OUT_W-1:0]    rsp_bin_count, rsp_total_samples, rsp_max_bin_count;
   logic                rsp_in_range, rsp_bad_range;
   logic [INDEX_W-1:0]  rsp_bin_x, rsp_bin_y, rsp_bin_z;
   logic [NZ_W-1:0]     rsp_distinct_bins;
   logic                csr_we = 1'b0;
   logic [CSR_IW-1:0]   csr_index = CSR_MIN_X;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   logic drain_on = 1'b0;   // receiver stalls randomly while this is high

   // current axis borders kept here so random samples aim near them
   logic [SAMPLE_W-1:0] lo_cur [3];
   logic [SAMPLE_W-1:0] hi_cur [3];
   int bins_cur;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   histogram_3d_binning_core u_dut (.*);

   hist3d_checker u_check (.*);

   // timeout guard; the reset clearing pass and each clear walk the whole cube
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL histogram_3d_binning_core");
         $finish;
      end
   end

   // receiver: random stalls, mostly short, sometimes long, sometimes none
   initial begin
      int n;
      @(negedge clock);
      forever begin
         rsp_stall <= 1'b0;
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
         repeat (n) @(negedge clock);
         if (drain_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            repeat (n) @(negedge clock);
         end
      end
   end

   // sender gap before a word
   task automatic idle_gap();
      int n;
      if ($urandom_range(0, 1) == 0) return;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(negedge clock);
   endtask

   // drives one word and holds it until accepted
   task automatic send_word(input cmd_type c, input logic [SAMPLE_W-1:0] sx,
                            input logic [SAMPLE_W-1:0] sy, input logic [SAMPLE_W-1:0] sz,
                            input logic m, input logic [INDEX_W-1:0] ix,
                            input logic [INDEX_W-1:0] iy, input logic [INDEX_W-1:0] iz);
      req_valid = 1'b1;
      req_cmd = c;
      req_sample_x = sx; req_sample_y = sy; req_sample_z = sz;
      req_masked = m;
      req_index_x = ix; req_index_y = iy; req_index_z = iz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // waits until all results are back plus slack for the block to settle
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DW-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MIN_X: lo_cur[0] = val;
         CSR_MAX_X: hi_cur[0] = val;
         CSR_MIN_Y: lo_cur[1] = val;
         CSR_MAX_Y: hi_cur[1] = val;
         CSR_MIN_Z: lo_cur[2] = val;
         CSR_MAX_Z: hi_cur[2] = val;
         CSR_BINS:  bins_cur = val;
         default: ;
      endcase
   endtask

   task automatic set_ranges(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                             input int nb);
      write_reg(CSR_MIN_X, lo); write_reg(CSR_MAX_X, hi);
      write_reg(CSR_MIN_Y, lo); write_reg(CSR_MAX_Y, hi);
      write_reg(CSR_MIN_Z, lo); write_reg(CSR_MAX_Z, hi);
      write_reg(CSR_BINS, nb);
   endtask

   // component mostly inside the axis, some near or beyond the borders
   function automatic logic [SAMPLE_W-1:0] pick_comp(input int a);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return lo_cur[a];
      if (r == 1) return hi_cur[a];
      if (r == 2) return $urandom();
      if (r == 3) return lo_cur[a] - 1;
      if (r == 4) return hi_cur[a] + 1;
      if (hi_cur[a] <= lo_cur[a]) return $urandom();
      return $urandom_range(lo_cur[a], hi_cur[a]);
   endfunction

   task automatic random_word();
      int r;
      cmd_type c;
      r = $urandom_range(0, 99);
      // mostly adds so counts pile up; clears are rare (each walks the cube)
      c = (r < 70) ? CMD_ADD : (r < 85) ? CMD_RDSMP : (r < 99) ? CMD_RDIDX : CMD_CLEAR;
      idle_gap();
      send_word(c, pick_comp(0), pick_comp(1), pick_comp(2), $urandom_range(0, 9) == 0,
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, bins_cur - 1),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, bins_cur - 1),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, bins_cur - 1));
   endtask

   initial begin
      for (int a = 0; a < 3; a++) begin
         lo_cur[a] = '0;
         hi_cur[a] = '1;
      end
      bins_cur = 32;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drain_on <= 1'b1;

      // directed: borders of the default full range, every command
      send_word(CMD_ADD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0, 0, 0);
      send_word(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0);
      send_word(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0);
      send_word(CMD_ADD, 16'h8000, 16'h0001, 16'hFFFE, 1'b1, 0, 0, 0);   // masked
      send_word(CMD_RDSMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0);
      send_word(CMD_RDSMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0, 0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd31, 5'd31, 5'd31);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd0, 5'd0, 5'd0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd1, 5'd2, 5'd3);
      send_word(CMD_CLEAR, 0, 0, 0, 1'b0, 0, 0, 0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd31, 5'd31, 5'd31);
      drain();

      // narrow axes, small bin count, below/above the borders
      set_ranges(16'd100, 16'd200, 2);
      send_word(CMD_ADD, 16'd100, 16'd200, 16'd150, 1'b0, 0, 0, 0);
      send_word(CMD_ADD, 16'd99, 16'd150, 16'd150, 1'b0, 0, 0, 0);
      send_word(CMD_ADD, 16'd150, 16'd201, 16'd150, 1'b0, 0, 0, 0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd2, 5'd0, 5'd0);   // index past bins
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd0, 5'd1, 5'd0);
      drain();

      // bin count below 2 and above the maximum clamp
      write_reg(CSR_BINS, 0);
      send_word(CMD_ADD, 16'd200, 16'd200, 16'd200, 1'b0, 0, 0, 0);
      drain();
      write_reg(CSR_BINS, 63);
      send_word(CMD_ADD, 16'd200, 16'd200, 16'd200, 1'b0, 0, 0, 0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd31, 5'd31, 5'd31);
      drain();

      // bad axes: max equal to min, then max below min; bad_range on all cmds
      write_reg(CSR_MAX_Y, 16'd100);
      send_word(CMD_ADD, 16'd150, 16'd100, 16'd150, 1'b0, 0, 0, 0);
      send_word(CMD_RDIDX, 0, 0, 0, 1'b0, 5'd0, 5'd0, 5'd0);
      drain();
      write_reg(CSR_MAX_Y, 16'd50);
      send_word(CMD_RDSMP, 16'd150, 16'd60, 16'd150, 1'b0, 0, 0, 0);
      send_word(CMD_CLEAR, 0, 0, 0, 1'b0, 0, 0, 0);
      drain();

      // random phases under varied settings, extremes among them
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: set_ranges(16'h0000, 16'hFFFF, 32);
            1: set_ranges(16'd0, 16'd3, 2);        // tiny axes: counts pile up
            2: set_ranges(16'd1000, 16'd1007, 4);
            default: begin
               for (int a = 0; a < 3; a++) begin
                  int lo;
                  lo = $urandom_range(0, 65000);
                  write_reg(csr_idx_type'(2 * a), lo);
                  write_reg(csr_idx_type'(2 * a + 1),
                            ($urandom_range(0, 15) == 0) ? lo : lo + $urandom_range(1, 500));
               end
               write_reg(CSR_BINS, $urandom_range(0, 63));
               bins_cur = (bins_cur < 2) ? 2 : (bins_cur > 32) ? 32 : bins_cur;
            end
         endcase
         for (int i = 0; i < 100; i++) begin
            random_word();
            // one hold-off until every result is back
            if (ph == 4 && i == 50)
               while (pending != 0) @(negedge clock);
         end
         drain();
      end

      drain_on <= 1'b0;
      drain();
      if (fail_count == 0)
         $display("PASS histogram_3d_binning_core");
      else
         $display("FAIL histogram_3d_binning_core");
      $finish;
   end

endmodule
